### design/bigram_histogram_counter_top_defines.svh
// ---------------------------------------------------------------------------
// Bigram histogram counter assertion macros
// Shared property shorthands for the port checker.
// ---------------------------------------------------------------------------
`ifndef BIGRAM_HISTOGRAM_COUNTER_TOP_DEFINES_SVH
`define BIGRAM_HISTOGRAM_COUNTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhc check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhc check failed");

`endif

### design/bhc_pkg.sv
// ---------------------------------------------------------------------------
// Bigram histogram counter package
// Sizes, command and result types and the byte-to-letter mapping.
// ---------------------------------------------------------------------------
package bhc_pkg;

  localparam int IDX_W         = 6;
  localparam int ALPHABET_SIZE = 57;
  localparam int COUNT_WIDTH   = 32;
  localparam int ACTIVE_W      = 12;

  // table is addressed as {row, column}, so unused rows/columns are padding
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LOWER_A     = 8'h61;
  localparam logic [7:0] LOWER_Z     = 8'h7A;
  localparam logic [7:0] LATIN_LO    = 8'hE0;
  localparam logic [7:0] LATIN_MID   = 8'hF6;
  localparam logic [7:0] LATIN_HI    = 8'hF8;
  localparam logic [7:0] LATIN_TOP   = 8'hFF;
  localparam logic [7:0] LATIN_LO_BASE = 8'd26;
  localparam logic [7:0] LATIN_HI_BASE = 8'd49;

  typedef enum logic [1:0] {
    CMD_NOPAIR,
    CMD_PAIR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic                   pair_counted;
    logic [IDX_W-1:0]       first_index;
    logic [IDX_W-1:0]       second_index;
    logic [COUNT_WIDTH-1:0] count_value;
    logic [ACTIVE_W-1:0]    active_pairs;
  } result_t;

  // returns {hit, index}; hit is low for a separator byte
  function automatic logic [IDX_W:0] letter_index(input logic [7:0] b);
    logic [7:0] lc;
    logic [7:0] idx;
    logic       hit;
    lc  = (b inside {[UPPER_A:UPPER_Z]}) ? b + CASE_OFFSET : b;
    hit = 1'b1;
    idx = '0;
    if (lc inside {[LOWER_A:LOWER_Z]}) begin
      idx = lc - LOWER_A;
    end else if (lc inside {[LATIN_LO:LATIN_MID]}) begin
      idx = lc - LATIN_LO + LATIN_LO_BASE;
    end else if (lc inside {[LATIN_HI:LATIN_TOP]}) begin
      idx = lc - LATIN_HI + LATIN_HI_BASE;
    end else begin
      hit = 1'b0;
    end
    if (idx >= 8'(ALPHABET_SIZE)) begin
      hit = 1'b0;
    end
    return {hit, idx[IDX_W-1:0]};
  endfunction

endpackage

### design/bhc_front.sv
// ---------------------------------------------------------------------------
// Bigram histogram counter front end
// Maps bytes to letters, tracks the pair chain and issues table commands.
// ---------------------------------------------------------------------------
module bhc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     opcode,
  input  logic [7:0]               text_byte,
  input  logic [bhc_pkg::IDX_W-1:0] read_row,
  input  logic [bhc_pkg::IDX_W-1:0] read_column,
  output bhc_pkg::cmd_t            cmd
);
  import bhc_pkg::*;

  logic [IDX_W-1:0] prev_idx_r, prev_idx_nxt;
  logic             prev_valid_r, prev_valid_nxt;
  logic [IDX_W:0]   letter;
  logic             hit;
  logic [IDX_W-1:0] idx;

  assign letter = letter_index(text_byte);
  assign hit    = letter[IDX_W];
  assign idx    = letter[IDX_W-1:0];

  always_comb begin
    prev_idx_nxt   = prev_idx_r;
    prev_valid_nxt = prev_valid_r;
    cmd.kind       = CMD_NOPAIR;
    cmd.row        = '0;
    cmd.col        = '0;
    if (opcode == OP_READ) begin
      cmd.kind = CMD_READ;
      cmd.row  = read_row;
      cmd.col  = read_column;
    end else if (!hit) begin
      // separator: break the chain
      if (accept) begin
        prev_valid_nxt = 1'b0;
      end
    end else begin
      if (prev_valid_r) begin
        cmd.kind = CMD_PAIR;
        cmd.row  = prev_idx_r;
        cmd.col  = idx;
      end
      if (accept) begin
        prev_idx_nxt   = idx;
        prev_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_idx_r   <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      prev_idx_r   <= prev_idx_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

endmodule

### design/bhc_cmd_queue.sv
// ---------------------------------------------------------------------------
// Bigram histogram counter command queue
// Short FIFO that decouples the front end from the table update pipeline.
// ---------------------------------------------------------------------------
module bhc_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bhc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output bhc_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import bhc_pkg::*;

  cmd_t                 q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/bhc_back.sv
// ---------------------------------------------------------------------------
// Bigram histogram counter back end
// Count table with read-modify-write pipeline, forwarding and result FIFO.
// ---------------------------------------------------------------------------
module bhc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  input  bhc_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             clear_busy,
  input  logic             out_pop,
  output logic             out_empty,
  output bhc_pkg::result_t out_result
);
  import bhc_pkg::*;

  // count table
  logic [COUNT_WIDTH-1:0] mem [MEM_DEPTH];
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [COUNT_WIDTH-1:0] rd_data_r;

  // clearing pass
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // update stage
  logic                   issue;
  logic                   s2_valid_r;
  cmd_t                   s2_cmd_r;
  logic [ADDR_W-1:0]      s2_addr;
  logic [COUNT_WIDTH-1:0] old_count;
  logic [COUNT_WIDTH-1:0] new_count;
  logic                   is_pair;
  logic                   in_range;
  logic [ACTIVE_W-1:0]    nz_r, nz_nxt;
  result_t                res;

  // last write, for an item that read the same entry before that write landed
  logic                   fw_valid_r;
  logic [ADDR_W-1:0]      fw_addr_r;
  logic [COUNT_WIDTH-1:0] fw_data_r;

  // result FIFO
  result_t              oq_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owr_ptr_r, ord_ptr_r;
  logic [OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                 out_do_pop;
  logic                 room;

  // keep a slot for the item already in the update stage
  assign room = ({1'b0, ocnt_r} + (OUT_CNT_W + 1)'(s2_valid_r)) <
                (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign issue      = !cmd_empty && !clr_busy_r && room;
  assign cmd_pop    = issue;
  assign clear_busy = clr_busy_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  assign s2_addr  = {s2_cmd_r.row, s2_cmd_r.col};
  assign is_pair  = s2_valid_r && (s2_cmd_r.kind == CMD_PAIR);
  assign in_range = ({1'b0, s2_cmd_r.row} < (IDX_W + 1)'(ALPHABET_SIZE)) &&
                    ({1'b0, s2_cmd_r.col} < (IDX_W + 1)'(ALPHABET_SIZE));

  always_comb begin
    old_count = (fw_valid_r && fw_addr_r == s2_addr) ? fw_data_r : rd_data_r;
    // hold at the maximum
    new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
    nz_nxt    = nz_r + ACTIVE_W'(is_pair && old_count == '0);
  end

  always_comb begin
    res.pair_counted = 1'b0;
    res.first_index  = '0;
    res.second_index = '0;
    res.count_value  = '0;
    res.active_pairs = nz_nxt;
    case (s2_cmd_r.kind)
      CMD_PAIR: begin
        res.pair_counted = 1'b1;
        res.first_index  = s2_cmd_r.row;
        res.second_index = s2_cmd_r.col;
        res.count_value  = new_count;
      end
      CMD_READ: begin
        res.first_index  = s2_cmd_r.row;
        res.second_index = s2_cmd_r.col;
        res.count_value  = in_range ? old_count : '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_we    = clr_busy_r || is_pair;
  assign mem_waddr = clr_busy_r ? clr_addr_r : s2_addr;
  assign mem_wdata = clr_busy_r ? '0 : new_count;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_r <= mem[{cmd.row, cmd.col}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_cmd_r <= cmd;
    end
    fw_addr_r <= s2_addr;
    fw_data_r <= new_count;
  end

  // result FIFO
  assign out_empty  = (ocnt_r == '0);
  assign out_do_pop = out_pop && !out_empty;
  assign out_result = oq_r[ord_ptr_r];
  assign ocnt_nxt   = ocnt_r + OUT_CNT_W'(s2_valid_r) - OUT_CNT_W'(out_do_pop);

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      oq_r[owr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s2_valid_r <= 1'b0;
      fw_valid_r <= 1'b0;
      nz_r       <= '0;
      owr_ptr_r  <= '0;
      ord_ptr_r  <= '0;
      ocnt_r     <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s2_valid_r <= issue;
      fw_valid_r <= is_pair;
      nz_r       <= s2_valid_r ? nz_nxt : nz_r;
      owr_ptr_r  <= s2_valid_r ? owr_ptr_r + 1'b1 : owr_ptr_r;
      ord_ptr_r  <= out_do_pop ? ord_ptr_r + 1'b1 : ord_ptr_r;
      ocnt_r     <= ocnt_nxt;
    end
  end

endmodule

### design/bigram_histogram_counter_top.sv
// ---------------------------------------------------------------------------
// Bigram histogram counter
// Counts adjacent letter pairs of a byte stream in a saturating table.
// ---------------------------------------------------------------------------
// Takes one item per clock while in_full is low, gives one result per item, in
// order. Each item goes through the command queue, the registered table read
// and the update stage into the result FIFO. The rate is set by the count
// table's single write port: each pair does one read-modify-write, pipelined
// over two stages with the last write forwarded, so repeated pairs still go at
// one per clock when nothing stalls. After reset a clearing pass zeroes every
// table entry, one per clock, with in_full held high until it is done.
// ---------------------------------------------------------------------------
module bigram_histogram_counter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_opcode,
  input  logic [7:0]                      in_text_byte,
  input  logic [bhc_pkg::IDX_W-1:0]       in_read_row,
  input  logic [bhc_pkg::IDX_W-1:0]       in_read_column,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic                            out_pair_counted,
  output logic [bhc_pkg::IDX_W-1:0]       out_first_index,
  output logic [bhc_pkg::IDX_W-1:0]       out_second_index,
  output logic [bhc_pkg::COUNT_WIDTH-1:0] out_count_value,
  output logic [bhc_pkg::ACTIVE_W-1:0]    out_active_pairs
);
  import bhc_pkg::*;

  logic    accept;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    clear_busy;
  cmd_t    front_cmd;
  cmd_t    queued_cmd;
  result_t result;

  assign in_full = cmd_full || clear_busy;
  assign accept  = in_push && !in_full;

  bhc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .opcode      (in_opcode),
    .text_byte   (in_text_byte),
    .read_row    (in_read_row),
    .read_column (in_read_column),
    .cmd         (front_cmd)
  );

  bhc_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (front_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_cmd  (queued_cmd),
    .empty    (cmd_empty)
  );

  bhc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (queued_cmd),
    .cmd_pop    (cmd_pop),
    .clear_busy (clear_busy),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_result (result)
  );

  assign out_pair_counted = result.pair_counted;
  assign out_first_index  = result.first_index;
  assign out_second_index = result.second_index;
  assign out_count_value  = result.count_value;
  assign out_active_pairs = result.active_pairs;

endmodule

### design/bhc_checker.sv
// ---------------------------------------------------------------------------
// Bigram histogram counter port checker
// Watches the top level ports and flags inconsistent results.
// ---------------------------------------------------------------------------
`include "bigram_histogram_counter_top_defines.svh"

module bhc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_pop,
  input logic                            out_empty,
  input logic                            out_pair_counted,
  input logic [bhc_pkg::COUNT_WIDTH-1:0] out_count_value,
  input logic [bhc_pkg::ACTIVE_W-1:0]    out_active_pairs
);
  import bhc_pkg::*;

  // a counted pair always has a nonzero count
  `BHC_ASSERT_NOW(a_counted_nonzero, !out_empty && out_pair_counted, out_count_value != '0)

  // a counted pair means at least one active entry
  `BHC_ASSERT_NOW(a_counted_active, !out_empty && out_pair_counted, out_active_pairs != '0)

  // any nonzero value shown implies an active entry
  `BHC_ASSERT_NOW(a_value_active, !out_empty && out_count_value != '0, out_active_pairs != '0)

  // a waiting result stays until taken
  `BHC_ASSERT_NEXT(a_result_held, !out_empty && !out_pop, !out_empty)

  // a waiting result keeps its count
  `BHC_ASSERT_NEXT(a_count_held, !out_empty && !out_pop, $stable(out_count_value))

endmodule

bind bigram_histogram_counter_top bhc_checker u_bhc_checker (.*);
